// ===== rtl/core/fths_pkg.sv =====
// ----------------------------------------------------------------------------
// fths_pkg
// Shared types and constants for the float tensor health scan.
// ----------------------------------------------------------------------------
package fths_pkg;

  localparam int INDEX_BITS = 32;

  // item index saturates at min(2^INDEX_BITS - 1, 0xFFFFFFFF)
  localparam logic [31:0] POS_LIMIT = (INDEX_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << INDEX_BITS) - 64'd1);

  localparam logic [30:0] FP32_INF_MAG  = 31'h7F80_0000;
  localparam logic [14:0] FP16_INF_MAG  = 15'h7C00;
  localparam logic [7:0]  FP16_EXP_BIAS = 8'd112;
  localparam logic [7:0]  FP16_SUB_BIAS = 8'd103;
  localparam logic [31:0] TALLY_MAX     = 32'hFFFF_FFFF;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;

  typedef enum logic {
    FMT_FP32 = 1'b0,
    FMT_FP16 = 1'b1
  } fmt_t;

  // register byte offsets (paddr[2] selects the word)
  localparam logic REG_INPUT_FORMAT = 1'b0;

  typedef struct packed {
    logic [30:0] mag;
    logic        bad;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] first_bad_index;
    logic        bad_found;
    logic [31:0] bad_count;
    logic [31:0] max_index;
    logic        max_found;
    logic [30:0] max_magnitude_bits;
  } result_t;

endpackage

// ===== rtl/core/float_tensor_health_scan_top.sv =====
// A last beat's summary is registered into m_tdata when the accumulator takes it.
// Throughput: 1 beat per cycle unless stalled (below); set by the decode/compare path.
// A summary held by m_tready stalls only at the next last beat.
// Reset (rst, synchronous, active high) clears the scan state, the output valid and
// input_format (fp32).
// ----------------------------------------------------------------------------
// float_tensor_health_scan_top
// Max finite magnitude and non-finite scan over fp32/fp16 streams.
// ----------------------------------------------------------------------------
module float_tensor_health_scan_top
  import fths_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] value_bits
  input  logic                  s_tlast,   // last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [30:0] max_magnitude_bits, [31] max_found, [63:32] max_index,
  // [95:64] bad_count, [96] bad_found, [128:97] first_bad_index, [135:129] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  fmt_t    input_format;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= FMT_FP32;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_INPUT_FORMAT) begin
      input_format <= fmt_t'(pwdata[0]);
    end
  end

  assign prdata = (paddr[2] == REG_INPUT_FORMAT) ? {31'd0, input_format} : 32'd0;

  fths_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .input_format (input_format),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item)
  );

  fths_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = {7'd0, result};

endmodule

// ===== rtl/core/fths_decode.sv =====
// ----------------------------------------------------------------------------
// fths_decode
// Input register and fp32/fp16 classification into an fp32 magnitude.
// ----------------------------------------------------------------------------
module fths_decode
  import fths_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // [31:0] value_bits
  input  logic                 s_tlast,
  input  fmt_t                 input_format,
  output logic                 item_valid,
  input  logic                 item_ready,
  output item_t                item
);

  logic        hold_valid;
  logic [31:0] hold_value;
  logic        hold_last;
  fmt_t        hold_fmt;

  logic [14:0] h_mag;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  lead;
  logic [23:0] sub_shift;
  logic [30:0] h_single;

  assign s_tready   = !hold_valid || item_ready;
  assign item_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_value <= s_tdata;
      hold_last  <= s_tlast;
      hold_fmt   <= input_format;
    end
  end

  // fp16 -> exact fp32 magnitude; subnormals normalized via leading-one
  always_comb begin
    h_mag = hold_value[14:0];
    h_exp = h_mag[14:10];
    h_man = h_mag[9:0];
    lead  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) lead = 4'(i);
    end
    sub_shift = 24'(h_man) << (5'd23 - 5'(lead));
    if (h_exp != 5'd0) begin
      h_single = {8'(h_exp) + FP16_EXP_BIAS, h_man, 13'd0};
    end else if (h_man == 10'd0) begin
      h_single = 31'd0;
    end else begin
      h_single = {8'(lead) + FP16_SUB_BIAS, sub_shift[22:0]};
    end
  end

  always_comb begin
    item.last = hold_last;
    case (hold_fmt)
      FMT_FP16: begin
        item.bad = (h_mag >= FP16_INF_MAG);
        item.mag = item.bad ? 31'd0 : h_single;
      end
      default: begin
        item.bad = (hold_value[30:0] >= FP32_INF_MAG);
        item.mag = hold_value[30:0];
      end
    endcase
  end

endmodule

// ===== rtl/core/fths_accum.sv =====
// ----------------------------------------------------------------------------
// fths_accum
// Running max / non-finite tally and the summary output register.
// ----------------------------------------------------------------------------
module fths_accum
  import fths_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t result
);

  logic [30:0] best_magnitude, best_magnitude_next;
  logic [31:0] best_position, best_position_next;
  logic        have_best, have_best_next;
  logic [31:0] item_position, item_position_next;
  logic [31:0] nonfinite_tally, nonfinite_tally_next;
  logic [31:0] first_nonfinite_position, first_nonfinite_position_next;
  logic        take;
  result_t     result_next;

  // a last beat needs room in the output register
  assign item_ready = !item.last || !m_tvalid || m_tready;
  assign take       = item_valid && item_ready;

  always_comb begin
    best_magnitude_next           = best_magnitude;
    best_position_next            = best_position;
    have_best_next                = have_best;
    nonfinite_tally_next          = nonfinite_tally;
    first_nonfinite_position_next = first_nonfinite_position;

    if (item.bad) begin
      if (nonfinite_tally == 32'd0) first_nonfinite_position_next = item_position;
      if (nonfinite_tally != TALLY_MAX) nonfinite_tally_next = nonfinite_tally + 32'd1;
    end else if (!have_best || item.mag > best_magnitude) begin
      best_magnitude_next = item.mag;
      best_position_next  = item_position;
      have_best_next      = 1'b1;
    end

    item_position_next = (item_position < POS_LIMIT) ? item_position + 32'd1
                                                     : item_position;

    result_next.max_magnitude_bits = have_best_next ? best_magnitude_next : 31'd0;
    result_next.max_found          = have_best_next;
    result_next.max_index          = have_best_next ? best_position_next : 32'd0;
    result_next.bad_count          = nonfinite_tally_next;
    result_next.bad_found          = (nonfinite_tally_next != 32'd0);
    result_next.first_bad_index    = (nonfinite_tally_next != 32'd0) ?
                                     first_nonfinite_position_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_magnitude           <= '0;
      best_position            <= '0;
      have_best                <= 1'b0;
      item_position            <= '0;
      nonfinite_tally          <= '0;
      first_nonfinite_position <= '0;
    end else if (take) begin
      if (item.last) begin
        best_magnitude           <= '0;
        best_position            <= '0;
        have_best                <= 1'b0;
        item_position            <= '0;
        nonfinite_tally          <= '0;
        first_nonfinite_position <= '0;
      end else begin
        best_magnitude           <= best_magnitude_next;
        best_position            <= best_position_next;
        have_best                <= have_best_next;
        item_position            <= item_position_next;
        nonfinite_tally          <= nonfinite_tally_next;
        first_nonfinite_position <= first_nonfinite_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && item.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) result <= result_next;
  end

endmodule

// ===== rtl/core/fths_checker.sv =====
// ----------------------------------------------------------------------------
// fths_checker
// Port-level checks on the summary output, bound to the top level.
// ----------------------------------------------------------------------------
module fths_checker
  import fths_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("summary beat changed while stalled");

  // no finite value seen -> magnitude and index are zero
  a_no_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[31] |-> m_tdata[30:0] == 31'd0 && m_tdata[63:32] == 32'd0)
    else $error("max fields nonzero without max_found");

  // bad flag tracks the count, first index zero when none
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[96] == (m_tdata[95:64] != 32'd0) &&
                 (m_tdata[96] || m_tdata[128:97] == 32'd0))
    else $error("bad_found inconsistent with bad_count");

  // reported max is finite and the padding bits are zero
  a_finite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[30:23] != 8'hFF && m_tdata[135:129] == 7'd0)
    else $error("non-finite max or nonzero padding");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind float_tensor_health_scan_top fths_checker u_fths_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
